// ===== design/mbrw_pkg.sv =====
// Shared types and constants for the macroblock-to-raster writer.
`default_nettype none

package mbrw_pkg;

    localparam int MAX_WIDTH_MB_DEFAULT  = 256;
    localparam int MAX_HEIGHT_MB_DEFAULT = 128;

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_LUMA = 2'd1,
        PH_CB   = 2'd2,
        PH_CR   = 2'd3
    } phase_t;

    localparam logic FUNC_SIZE  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    localparam logic [1:0] PLANE_Y  = 2'd0;
    localparam logic [1:0] PLANE_CB = 2'd1;
    localparam logic [1:0] PLANE_CR = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FRAME  = 2'd1;
    localparam logic [1:0] STATUS_MID_FRAME = 2'd2;

    typedef struct packed {
        logic       func;
        logic [8:0] width_mb;
        logic [7:0] height_mb;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic        write_enable;
        logic [1:0]  plane;
        logic [22:0] write_address;
        logic [7:0]  write_value;
        logic        frame_done;
        logic [15:0] frames_completed;
        logic [1:0]  status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mbrw_in_reg.sv =====
// Input register stage: holds one accepted word until the core consumes it.
`default_nettype none

module mbrw_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mbrw_pkg::in_item_t in_item,
    input  wire logic              advance,
    output logic                   item_valid,
    output mbrw_pkg::in_item_t     item
);
    import mbrw_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/mbrw_core.sv =====
// Raster position state and per-word address and status computation.
`default_nettype none

module mbrw_core #(
    parameter int MAX_WIDTH_MB  = mbrw_pkg::MAX_WIDTH_MB_DEFAULT,
    parameter int MAX_HEIGHT_MB = mbrw_pkg::MAX_HEIGHT_MB_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire mbrw_pkg::in_item_t item,
    output mbrw_pkg::result_t       result
);
    import mbrw_pkg::*;

    phase_t      phase_reg,           phase_next;
    logic [7:0]  byte_in_block_reg,   byte_in_block_next;
    logic [12:0] luma_column_reg,     luma_column_next;
    logic [22:0] luma_row_base_reg,   luma_row_base_next;
    logic [11:0] chroma_column_reg,   chroma_column_next;
    logic [20:0] chroma_row_base_reg, chroma_row_base_next;
    logic [12:0] luma_stride_reg,     luma_stride_next;
    logic [15:0] blocks_done_reg,     blocks_done_next;
    logic [15:0] blocks_total_reg,    blocks_total_next;
    logic [15:0] frame_count_reg,     frame_count_next;

    logic [8:0]  width_clamped;
    logic [7:0]  height_clamped;
    logic [15:0] total_new;
    logic [11:0] chroma_stride;
    logic [16:0] luma_row_offset;
    logic [14:0] chroma_row_offset;
    logic [5:0]  chroma_byte;
    logic [22:0] luma_address;
    logic [22:0] chroma_address;
    logic [15:0] blocks_done_inc;

    assign width_clamped  = (item.width_mb > 9'(MAX_WIDTH_MB)) ? 9'(MAX_WIDTH_MB)
                                                               : item.width_mb;
    assign height_clamped = (item.height_mb > 8'(MAX_HEIGHT_MB)) ? 8'(MAX_HEIGHT_MB)
                                                                 : item.height_mb;
    assign total_new      = 16'(width_clamped) * 16'(height_clamped);

    assign chroma_stride     = luma_stride_reg[12:1];
    assign chroma_byte       = byte_in_block_reg[5:0];
    assign luma_row_offset   = 17'(byte_in_block_reg[7:4]) * 17'(luma_stride_reg);
    assign chroma_row_offset = 15'(chroma_byte[5:3]) * 15'(chroma_stride);
    assign luma_address      = luma_row_base_reg + 23'(luma_row_offset)
                             + 23'(luma_column_reg) + 23'(byte_in_block_reg[3:0]);
    assign chroma_address    = 23'(chroma_row_base_reg) + 23'(chroma_row_offset)
                             + 23'(chroma_column_reg) + 23'(chroma_byte[2:0]);
    assign blocks_done_inc   = blocks_done_reg + 16'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        byte_in_block_next   = byte_in_block_reg;
        luma_column_next     = luma_column_reg;
        luma_row_base_next   = luma_row_base_reg;
        chroma_column_next   = chroma_column_reg;
        chroma_row_base_next = chroma_row_base_reg;
        luma_stride_next     = luma_stride_reg;
        blocks_done_next     = blocks_done_reg;
        blocks_total_next    = blocks_total_reg;
        frame_count_next     = frame_count_reg;

        result               = '0;

        if (item.func == FUNC_SIZE)
        begin
            if (phase_reg != PH_SIZE)
            begin
                result.status = STATUS_MID_FRAME;
            end
            else
            begin
                luma_stride_next     = 13'({width_clamped, 4'b0000});
                blocks_total_next    = total_new;
                blocks_done_next     = '0;
                byte_in_block_next   = '0;
                luma_column_next     = '0;
                luma_row_base_next   = '0;
                chroma_column_next   = '0;
                chroma_row_base_next = '0;
                if (total_new == 16'd0)
                begin
                    // empty picture completes at once
                    result.frame_done = 1'b1;
                    frame_count_next  = frame_count_reg + 16'd1;
                end
                else
                begin
                    phase_next = PH_LUMA;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_SIZE:
                begin
                    result.status = STATUS_NO_FRAME;
                end
                PH_LUMA:
                begin
                    result.write_enable  = 1'b1;
                    result.write_value   = item.pixel_value;
                    result.plane         = PLANE_Y;
                    result.write_address = luma_address;
                    if (byte_in_block_reg == 8'd255)
                    begin
                        byte_in_block_next = '0;
                        luma_column_next   = luma_column_reg + 13'd16;
                        phase_next         = PH_CB;
                    end
                    else
                    begin
                        byte_in_block_next = byte_in_block_reg + 8'd1;
                    end
                end
                default:
                begin
                    result.write_enable  = 1'b1;
                    result.write_value   = item.pixel_value;
                    result.plane         = (phase_reg == PH_CB) ? PLANE_CB : PLANE_CR;
                    result.write_address = chroma_address;
                    if (chroma_byte == 6'd63)
                    begin
                        byte_in_block_next = '0;
                        if (phase_reg == PH_CB)
                        begin
                            phase_next = PH_CR;
                        end
                        else
                        begin
                            chroma_column_next = chroma_column_reg + 12'd8;
                            // right edge: wrap to the next macroblock row
                            if (luma_column_reg == luma_stride_reg)
                            begin
                                luma_column_next     = '0;
                                chroma_column_next   = '0;
                                luma_row_base_next   = luma_row_base_reg
                                                     + 23'({luma_stride_reg, 4'b0000});
                                chroma_row_base_next = chroma_row_base_reg
                                                     + 21'({chroma_stride, 3'b000});
                            end
                            blocks_done_next = blocks_done_inc;
                            if (blocks_done_inc >= blocks_total_reg)
                            begin
                                result.frame_done = 1'b1;
                                frame_count_next  = frame_count_reg + 16'd1;
                                phase_next        = PH_SIZE;
                            end
                            else
                            begin
                                phase_next = PH_LUMA;
                            end
                        end
                    end
                    else
                    begin
                        byte_in_block_next = {2'b00, chroma_byte} + 8'd1;
                    end
                end
            endcase
        end

        result.frames_completed = frame_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_SIZE;
            byte_in_block_reg   <= '0;
            luma_column_reg     <= '0;
            luma_row_base_reg   <= '0;
            chroma_column_reg   <= '0;
            chroma_row_base_reg <= '0;
            luma_stride_reg     <= '0;
            blocks_done_reg     <= '0;
            blocks_total_reg    <= '0;
            frame_count_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg           <= phase_next;
            byte_in_block_reg   <= byte_in_block_next;
            luma_column_reg     <= luma_column_next;
            luma_row_base_reg   <= luma_row_base_next;
            chroma_column_reg   <= chroma_column_next;
            chroma_row_base_reg <= chroma_row_base_next;
            luma_stride_reg     <= luma_stride_next;
            blocks_done_reg     <= blocks_done_next;
            blocks_total_reg    <= blocks_total_next;
            frame_count_reg     <= frame_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/macroblock_to_raster_writer_unit.sv =====
// Top level of the macroblock-to-raster writer: input stage, core and result register.
//
//   channel | signals                                         | dir | word
//   --------+-------------------------------------------------+-----+---------------------
//   in      | in_valid in_ready func width_mb height_mb       | in  | size item or sample
//           | pixel_value                                     |     |
//   out     | out_valid out_ready write_enable plane          | out | one result per word
//           | write_address write_value frame_done            |     |
//           | frames_completed status                         |     |
//
// One word per cycle sustained while out is not stalled; an accepted word is held in the
// input register, then its result passes the address logic into the result register.
// Reset clears the picture state and frame count; the block waits for a size word.
// A stall on out holds the result register and backs up into the input register;
// in_ready drops only when both stages hold a word and out is stalled.
`default_nettype none

module macroblock_to_raster_writer_unit #(
    parameter int MAX_WIDTH_MB  = mbrw_pkg::MAX_WIDTH_MB_DEFAULT,
    parameter int MAX_HEIGHT_MB = mbrw_pkg::MAX_HEIGHT_MB_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [8:0]  width_mb,
    input  wire logic [7:0]  height_mb,
    input  wire logic [7:0]  pixel_value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             write_enable,
    output logic [1:0]       plane,
    output logic [22:0]      write_address,
    output logic [7:0]       write_value,
    output logic             frame_done,
    output logic [15:0]      frames_completed,
    output logic [1:0]       status
);
    import mbrw_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     fire;
    result_t  result;
    result_t  result_reg;
    logic     out_valid_reg;

    assign in_item.func        = func;
    assign in_item.width_mb    = width_mb;
    assign in_item.height_mb   = height_mb;
    assign in_item.pixel_value = pixel_value;

    assign advance = !out_valid_reg || out_ready;
    assign fire    = item_valid && advance;

    mbrw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mbrw_core #(
        .MAX_WIDTH_MB  (MAX_WIDTH_MB),
        .MAX_HEIGHT_MB (MAX_HEIGHT_MB)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign write_enable     = result_reg.write_enable;
    assign plane            = result_reg.plane;
    assign write_address    = result_reg.write_address;
    assign write_value      = result_reg.write_value;
    assign frame_done       = result_reg.frame_done;
    assign frames_completed = result_reg.frames_completed;
    assign status           = result_reg.status;

endmodule

`default_nettype wire

// ===== sim/macroblock_to_raster_writer_unit_test.sv =====
// Self-checking testbench for the macroblock-to-raster writer: predicts every result and compares.
`default_nettype none

module macroblock_to_raster_writer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrw_pkg::*;

    localparam int BYTES_PER_MB = 384;

    class raster_scoreboard;
        int          max_w;
        int          max_h;
        phase_t      stage;
        logic [7:0]  sample_idx;
        logic [12:0] y_col;
        logic [22:0] y_row_base;
        logic [11:0] c_col;
        logic [20:0] c_row_base;
        logic [12:0] y_stride;
        logic [15:0] mbs_written;
        logic [15:0] mbs_total;
        logic [15:0] pictures_done;
        result_t     expected_q[$];
        int          mismatches;

        function new(int mw, int mh);
            max_w         = mw;
            max_h         = mh;
            stage         = PH_SIZE;
            sample_idx    = '0;
            y_col         = '0;
            y_row_base    = '0;
            c_col         = '0;
            c_row_base    = '0;
            y_stride      = '0;
            mbs_written   = '0;
            mbs_total     = '0;
            pictures_done = '0;
            mismatches    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        // Works out the result of one accepted word and queues it.
        function void note_word(in_item_t w);
            result_t     r;
            logic [31:0] wmb;
            logic [31:0] hmb;
            logic [31:0] b;
            logic [31:0] cstride;
            logic [31:0] addr;
            r = '0;
            r.status = STATUS_OK;
            if (w.func == FUNC_SIZE)
            begin
                if (stage != PH_SIZE)
                begin
                    r.status = STATUS_MID_FRAME;
                end
                else
                begin
                    wmb = 32'(w.width_mb);
                    hmb = 32'(w.height_mb);
                    if (wmb > max_w) wmb = max_w;
                    if (hmb > max_h) hmb = max_h;
                    y_stride    = 13'(wmb * 16);
                    mbs_total   = 16'(wmb * hmb);
                    mbs_written = '0;
                    sample_idx  = '0;
                    y_col       = '0;
                    y_row_base  = '0;
                    c_col       = '0;
                    c_row_base  = '0;
                    if (mbs_total == 0)
                    begin
                        r.frame_done  = 1'b1;
                        pictures_done = pictures_done + 16'd1;
                        stage         = PH_SIZE;
                    end
                    else
                    begin
                        stage = PH_LUMA;
                    end
                end
            end
            else if (stage == PH_SIZE)
            begin
                r.status = STATUS_NO_FRAME;
            end
            else
            begin
                cstride        = 32'(y_stride) >> 1;
                r.write_enable = 1'b1;
                r.write_value  = w.pixel_value;
                if (stage == PH_LUMA)
                begin
                    b       = 32'(sample_idx);
                    r.plane = PLANE_Y;
                    addr    = y_row_base + (b >> 4) * y_stride + y_col + (b & 15);
                    if (b == 255)
                    begin
                        sample_idx = '0;
                        y_col      = y_col + 13'd16;
                        stage      = PH_CB;
                    end
                    else
                    begin
                        sample_idx = 8'(b + 1);
                    end
                end
                else
                begin
                    b       = 32'(sample_idx) & 63;
                    r.plane = (stage == PH_CB) ? PLANE_CB : PLANE_CR;
                    addr    = c_row_base + (b >> 3) * cstride + c_col + (b & 7);
                    if (b == 63)
                    begin
                        sample_idx = '0;
                        if (stage == PH_CB)
                        begin
                            stage = PH_CR;
                        end
                        else
                        begin
                            c_col = c_col + 12'd8;
                            // right edge: back to column 0, one macroblock row down
                            if (y_col == y_stride)
                            begin
                                y_col      = '0;
                                c_col      = '0;
                                y_row_base = 23'(y_row_base + 16 * y_stride);
                                c_row_base = 21'(c_row_base + 8 * cstride);
                            end
                            mbs_written = mbs_written + 16'd1;
                            if (mbs_written >= mbs_total)
                            begin
                                r.frame_done  = 1'b1;
                                pictures_done = pictures_done + 16'd1;
                                stage         = PH_SIZE;
                            end
                            else
                            begin
                                stage = PH_LUMA;
                            end
                        end
                    end
                    else
                    begin
                        sample_idx = 8'(b + 1);
                    end
                end
                r.write_address = addr[22:0];
            end
            r.frames_completed = pictures_done;
            expected_q.push_back(r);
        endfunction

        task check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected result word", 32'(got), 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.write_enable !== want.write_enable)
                report_mismatch("write_enable", 32'(got.write_enable),
                                32'(want.write_enable));
            if (got.plane !== want.plane)
                report_mismatch("plane", 32'(got.plane), 32'(want.plane));
            if (got.write_address !== want.write_address)
                report_mismatch("write_address", 32'(got.write_address),
                                32'(want.write_address));
            if (got.write_value !== want.write_value)
                report_mismatch("write_value", 32'(got.write_value), 32'(want.write_value));
            if (got.frame_done !== want.frame_done)
                report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
            if (got.frames_completed !== want.frames_completed)
                report_mismatch("frames_completed", 32'(got.frames_completed),
                                32'(want.frames_completed));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [8:0]  width_mb;
    logic [7:0]  height_mb;
    logic [7:0]  pixel_value;
    logic        out_valid;
    logic        out_ready;
    logic        write_enable;
    logic [1:0]  plane;
    logic [22:0] write_address;
    logic [7:0]  write_value;
    logic        frame_done;
    logic [15:0] frames_completed;
    logic [1:0]  status;

    raster_scoreboard sb;
    int               words_sent;
    int               burst_left;

    macroblock_to_raster_writer_unit dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("macroblock_to_raster_writer_unit_test: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        in_item_t word;
        result_t  res;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                word.func        = func;
                word.width_mb    = width_mb;
                word.height_mb   = height_mb;
                word.pixel_value = pixel_value;
                sb.note_word(word);
            end
            if (out_valid && out_ready)
            begin
                res.write_enable     = write_enable;
                res.plane            = plane;
                res.write_address    = write_address;
                res.write_value      = write_value;
                res.frame_done       = frame_done;
                res.frames_completed = frames_completed;
                res.status           = status;
                sb.check_result(res);
            end
        end
    end

    // receiver: picks a random stall mode and holds it for a random span
    initial
    begin
        int         mode;
        int         span;
        logic [7:0] pattern;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            span    = $urandom_range(20, 400);
            pattern = 8'($urandom) | 8'h01;
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 3) != 0);
                    2: out_ready = 1'($urandom_range(0, 1));
                    default:
                    begin
                        out_ready = pattern[0];
                        pattern   = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    task automatic send_word(input logic f, input logic [8:0] w, input logic [7:0] h,
                             input logic [7:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            burst_left = $urandom_range(1, 64);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid    = 1'b1;
        func        = f;
        width_mb    = w;
        height_mb   = h;
        pixel_value = v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    // hold the sender until every queued result has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic send_empty();
        if ($urandom_range(0, 1))
            send_word(FUNC_SIZE, 9'd0, 8'($urandom), 8'($urandom));
        else
            send_word(FUNC_SIZE, 9'($urandom), 8'd0, 8'($urandom));
    endtask

    // size word, then every sample of the picture; noise_pct adds ignored size words
    task automatic send_picture(input int w, input int h, input int noise_pct);
        int         cw;
        int         ch;
        int         n;
        logic [7:0] v;
        cw = (w > MAX_WIDTH_MB_DEFAULT) ? MAX_WIDTH_MB_DEFAULT : w;
        ch = (h > MAX_HEIGHT_MB_DEFAULT) ? MAX_HEIGHT_MB_DEFAULT : h;
        n  = cw * ch * BYTES_PER_MB;
        send_word(FUNC_SIZE, 9'(w), 8'(h), 8'($urandom));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(FUNC_SIZE, 9'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 9) == 0)
                v = $urandom_range(0, 1) ? 8'hff : 8'h00;
            else
                v = 8'($urandom);
            send_word(FUNC_PIXEL, 9'($urandom), 8'($urandom), v);
        end
    endtask

    initial
    begin
        int pick;
        sb          = new(MAX_WIDTH_MB_DEFAULT, MAX_HEIGHT_MB_DEFAULT);
        words_sent  = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_SIZE;
        width_mb    = '0;
        height_mb   = '0;
        pixel_value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: samples with nothing open, empty pictures, one two-macroblock picture
        send_word(FUNC_PIXEL, 9'd0, 8'd0, 8'h00);
        send_word(FUNC_PIXEL, 9'h1ff, 8'hff, 8'hff);
        send_word(FUNC_SIZE, 9'd0, 8'd0, 8'h00);
        send_word(FUNC_SIZE, 9'd0, 8'hff, 8'hff);
        send_word(FUNC_SIZE, 9'h1ff, 8'd0, 8'h00);
        send_word(FUNC_SIZE, 9'd256, 8'd0, 8'h00);
        if ($urandom_range(0, 1))
            send_picture(2, 1, 3);
        else
            send_picture(1, 2, 3);
        send_word(FUNC_PIXEL, 9'd0, 8'd0, 8'h5a);
        send_word(FUNC_SIZE, 9'd1, 8'd0, 8'h00);
        wait_idle();

        // random: stray samples and empty pictures
        while (words_sent < 1050)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                repeat ($urandom_range(1, 4))
                    send_word(FUNC_PIXEL, 9'($urandom), 8'($urandom), 8'($urandom));
            else if (pick < 95)
                send_empty();
            else
                wait_idle();
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("macroblock_to_raster_writer_unit_test: PASS");
        else
            $display("macroblock_to_raster_writer_unit_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/mbrw_pkg.sv
design/mbrw_in_reg.sv
design/mbrw_core.sv
design/macroblock_to_raster_writer_unit.sv
sim/macroblock_to_raster_writer_unit_test.sv
